### sv/gzhs_pkg.sv
// Package for the gzip header stripper: item types, parse phases, status codes
// and the header constants shared by the parser, the result queue and the top.
// No dependencies.
`timescale 1ns / 1ps

package gzhs_pkg;

   // Header constants
   localparam logic [7:0] MAGIC_1        = 8'h1F;
   localparam logic [7:0] MAGIC_2        = 8'h8B;
   localparam logic [7:0] METHOD_DEFLATE = 8'h08;
   localparam logic [7:0] FLG_HCRC       = 8'h02;
   localparam logic [7:0] FLG_EXTRA      = 8'h04;
   localparam logic [7:0] FLG_NAME       = 8'h08;
   localparam logic [7:0] FLG_COMMENT    = 8'h10;

   // Bytes after the flag byte in the fixed header, and length of the header CRC
   localparam int FIXED_LEN = 6;
   localparam int HCRC_LEN  = 2;

   // Trailer hold line (CRC32 + ISIZE)
   localparam int HOLD_DEPTH = 8;
   localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
   localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);

   // Result queue
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_W       = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_CNT_W       = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_GZIP   = 2'd1,
      ST_BAD_METHOD = 2'd2,
      ST_TRUNCATED  = 2'd3
   } status_type;

   typedef enum logic [12:0] {
      PH_MAGIC1  = 13'h0001,
      PH_MAGIC2  = 13'h0002,
      PH_METHOD  = 13'h0004,
      PH_FLAGS   = 13'h0008,
      PH_FIXED   = 13'h0010,
      PH_XLEN_LO = 13'h0020,
      PH_XLEN_HI = 13'h0040,
      PH_EXTRA   = 13'h0080,
      PH_NAME    = 13'h0100,
      PH_COMMENT = 13'h0200,
      PH_HCRC    = 13'h0400,
      PH_PAYLOAD = 13'h0800,
      PH_ERROR   = 13'h1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_payload;
      logic [1:0] status;
      logic       end_of_run;
   } rsp_type;

   // Results of one item handed from the parser to the queue, in order
   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type rsp0;
      rsp_type rsp1;
   } push_type;

endpackage

### sv/gzhs_parser.sv
// Header parser and trailer hold line: updates the parse state for each accepted
// item and produces up to two results. Depends on gzhs_pkg.
`timescale 1ns / 1ps

module gzhs_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  gzhs_pkg::req_type req_data,
   output gzhs_pkg::push_type push
);
   import gzhs_pkg::*;

   // Starting points for the search over the optional fields
   localparam logic [1:0] FROM_EXTRA   = 2'd0;
   localparam logic [1:0] FROM_NAME    = 2'd1;
   localparam logic [1:0] FROM_COMMENT = 2'd2;
   localparam logic [1:0] FROM_HCRC    = 2'd3;

   phase_type               phase_ff, phase_in;
   logic [3:0]              hcount_ff, hcount_in;
   logic [7:0]              flag_ff, flag_in;
   logic [15:0]             extra_ff, extra_in;
   logic [HOLD_CNT_W-1:0]   hold_cnt_ff, hold_cnt_in;
   status_type              err_ff, err_in;
   logic [7:0]              hold_ff [HOLD_DEPTH];
   logic [7:0]              hold_in [HOLD_DEPTH];

   logic       hold_full;
   logic       emit;
   logic [7:0] b;
   status_type end_status;
   rsp_type    pay_rsp, end_rsp;

   function automatic phase_type next_field(input logic [1:0] from,
                                            input logic [7:0] flags);
      phase_type ph;
      priority if (from == FROM_EXTRA && (flags & FLG_EXTRA) != 8'h00) begin
         ph = PH_XLEN_LO;
      end else if (from <= FROM_NAME && (flags & FLG_NAME) != 8'h00) begin
         ph = PH_NAME;
      end else if (from <= FROM_COMMENT && (flags & FLG_COMMENT) != 8'h00) begin
         ph = PH_COMMENT;
      end else if (from <= FROM_HCRC && (flags & FLG_HCRC) != 8'h00) begin
         ph = PH_HCRC;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

   assign b         = req_data.data_byte;
   assign hold_full = (hold_cnt_ff == HOLD_CNT_W'(HOLD_DEPTH));

   always_comb begin
      phase_in    = phase_ff;
      hcount_in   = hcount_ff;
      flag_in     = flag_ff;
      extra_in    = extra_ff;
      hold_cnt_in = hold_cnt_ff;
      err_in      = err_ff;
      hold_in     = hold_ff;
      emit        = 1'b0;

      unique case (phase_ff)
         PH_MAGIC1: begin
            if (b == MAGIC_1) begin
               phase_in = PH_MAGIC2;
            end else begin
               err_in   = ST_NOT_GZIP;
               phase_in = PH_ERROR;
            end
         end
         PH_MAGIC2: begin
            if (b == MAGIC_2) begin
               phase_in = PH_METHOD;
            end else begin
               err_in   = ST_NOT_GZIP;
               phase_in = PH_ERROR;
            end
         end
         PH_METHOD: begin
            if (b == METHOD_DEFLATE) begin
               phase_in = PH_FLAGS;
            end else begin
               err_in   = ST_BAD_METHOD;
               phase_in = PH_ERROR;
            end
         end
         PH_FLAGS: begin
            flag_in   = b;
            hcount_in = 4'd0;
            phase_in  = PH_FIXED;
         end
         PH_FIXED: begin
            hcount_in = hcount_ff + 4'd1;
            if (hcount_in >= 4'(FIXED_LEN)) begin
               phase_in = next_field(FROM_EXTRA, flag_ff);
            end
         end
         PH_XLEN_LO: begin
            extra_in = {8'h00, b};
            phase_in = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            extra_in = {b, extra_ff[7:0]};
            phase_in = (extra_in == 16'h0000) ? next_field(FROM_NAME, flag_ff) : PH_EXTRA;
         end
         PH_EXTRA: begin
            extra_in = extra_ff - 16'd1;
            if (extra_in == 16'h0000) begin
               phase_in = next_field(FROM_NAME, flag_ff);
            end
         end
         PH_NAME: begin
            if (b == 8'h00) begin
               phase_in = next_field(FROM_COMMENT, flag_ff);
            end
         end
         PH_COMMENT: begin
            if (b == 8'h00) begin
               phase_in = next_field(FROM_HCRC, flag_ff);
            end
         end
         PH_HCRC: begin
            hcount_in = hcount_ff + 4'd1;
            if (hcount_in >= 4'(HCRC_LEN)) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (hold_full) begin
               // oldest byte leaves, newest enters at the tail
               emit = 1'b1;
               for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                  hold_in[i] = hold_ff[i+1];
               end
               hold_in[HOLD_DEPTH-1] = b;
            end else begin
               hold_in[hold_cnt_ff[HOLD_IDX_W-1:0]] = b;
               hold_cnt_in = hold_cnt_ff + 1'b1;
            end
         end
         PH_ERROR: begin
            phase_in = PH_ERROR;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // header CRC counts from zero
      if (phase_ff != PH_HCRC && phase_in == PH_HCRC) begin
         hcount_in = 4'd0;
      end

      // status of the file, from the state after this byte
      priority if (err_in != ST_OK) begin
         end_status = err_in;
      end else if (phase_in == PH_MAGIC1 || phase_in == PH_MAGIC2) begin
         end_status = ST_NOT_GZIP;
      end else if (phase_in != PH_PAYLOAD || hold_cnt_in != HOLD_CNT_W'(HOLD_DEPTH)) begin
         end_status = ST_TRUNCATED;
      end else begin
         end_status = ST_OK;
      end

      pay_rsp.out_byte   = hold_ff[0];
      pay_rsp.is_payload = 1'b1;
      pay_rsp.status     = ST_OK;
      pay_rsp.end_of_run = ~req_data.last;

      end_rsp.out_byte   = 8'h00;
      end_rsp.is_payload = 1'b0;
      end_rsp.status     = end_status;
      end_rsp.end_of_run = 1'b1;

      push.push0 = accept && (emit || req_data.last);
      push.push1 = accept && emit && req_data.last;
      push.rsp0  = emit ? pay_rsp : end_rsp;
      push.rsp1  = end_rsp;

      // final byte: back to the start for the next file
      if (req_data.last) begin
         phase_in    = PH_MAGIC1;
         hcount_in   = 4'd0;
         flag_in     = 8'h00;
         extra_in    = 16'h0000;
         hold_cnt_in = '0;
         err_in      = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC1;
         hcount_ff   <= 4'd0;
         flag_ff     <= 8'h00;
         extra_ff    <= 16'h0000;
         hold_cnt_ff <= '0;
         err_ff      <= ST_OK;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hcount_ff   <= hcount_in;
         flag_ff     <= flag_in;
         extra_ff    <= extra_in;
         hold_cnt_ff <= hold_cnt_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

### sv/gzhs_rsp_queue.sv
// Result queue: takes up to two results a cycle from the parser and hands out
// one per cycle on the result channel unless stalled. Depends on gzhs_pkg.
`timescale 1ns / 1ps

module gzhs_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  gzhs_pkg::push_type push,
   output logic               no_room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gzhs_pkg::rsp_type  rsp_data
);
   import gzhs_pkg::*;

   rsp_type                entry_ff [RSP_QUEUE_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   logic [RSP_PTR_W-1:0]   tail_next;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // an item may bring two results
   assign no_room   = (count_ff > RSP_CNT_W'(RSP_QUEUE_DEPTH - 2));
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      head_in  = head_ff + RSP_PTR_W'(pop);
      tail_in  = tail_ff + RSP_PTR_W'(push.push0) + RSP_PTR_W'(push.push1);
      count_in = count_ff + RSP_CNT_W'(push.push0) + RSP_CNT_W'(push.push1)
                 - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[tail_ff] <= push.rsp0;
      end
      if (push.push1) begin
         entry_ff[tail_next] <= push.rsp1;
      end
   end

endmodule

### sv/gzip_header_stripper_top.sv
// gzip header stripper, top level: parser feeding a small result queue.
// Depends on gzhs_pkg, gzhs_parser and gzhs_rsp_queue.
`timescale 1ns / 1ps

// Takes a gzip file one byte per item on req_ (last marks the final byte) and
// returns the raw deflate payload one byte per item on rsp_, then one status
// item (is_payload 0) for the file: ok, not gzip, unsupported method or
// truncated. The header is checked and skipped, and the eight trailer bytes are
// held back and never sent. A byte is taken every cycle while req_stall is low;
// the state update of one byte is a single registered step, and its results are
// written into the result queue, which offers them on rsp_. Payload results lag
// their input by eight bytes. The final byte of a file can produce two results,
// which a four-entry result queue absorbs; req_stall rises only while that queue
// holds more than two results. With a consumer that never stalls the queue never
// holds more than two, so a byte is taken in every cycle with no pause.

module gzip_header_stripper_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gzhs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gzhs_pkg::rsp_type rsp_data
);
   import gzhs_pkg::*;

   logic     accept;
   push_type push;

   assign accept = req_valid && !req_stall;

   gzhs_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   gzhs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .no_room   (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // final byte always yields an end status result
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |->
         ((push.push1 && !push.rsp1.is_payload && push.rsp1.end_of_run) ||
          (push.push0 && !push.push1 && !push.rsp0.is_payload && push.rsp0.end_of_run)))
      else $error("final byte without end status result");

   // results appear only for accepted items
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |-> (!push.push0 && !push.push1))
      else $error("result pushed without an accepted item");

   // second slot only filled with the first
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (push.push0 && push.rsp0.is_payload && !push.rsp0.end_of_run))
      else $error("result order broken");

   // queue empties only by delivering
   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid) && !$past(reset)) |-> $past(!rsp_stall))
      else $error("result dropped while stalled");

endmodule
